// ===== design/utf8_text_to_key_slots_unit_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 key slot unit: assertion macros
// Concurrent check helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_TO_KEY_SLOTS_UNIT_MACROS_SVH
`define UTF8_TEXT_TO_KEY_SLOTS_UNIT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define UTTS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("utts: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define UTTS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("utts: next-cycle check failed");
`else
`define UTTS_ASSERT_SAME(label, pre, post)
`define UTTS_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== design/utts_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 key slot unit: shared package
// Sizes, status codes, the key code table and the types passed between blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package utts_pkg;

  localparam int KEY_SLOTS   = 47;
  localparam int TABLE_DEPTH = 47;
  localparam int MAX_CHARS   = 256;
  localparam int CNT_W       = $clog2(MAX_CHARS + 1);
  localparam int CP_W        = 21;
  localparam int SLOT_W      = 6;
  localparam int KEY_W       = 6;
  localparam int BYTE_W      = 8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_LIMIT = 2'd2
  } status_e;

  // Printable evdev codes, one per slot.
  localparam logic [KEY_W-1:0] KEY_CODES [TABLE_DEPTH] = '{
    6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
    6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53
  };

  // What the decoder makes of one accepted byte.
  typedef struct packed {
    logic            chr;
    logic            err;
    status_e         status;
    logic [CP_W-1:0] cp;
    logic            eol;
  } dec_evt_t;

  // Command broadcast to every slot cell.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            alloc;
    logic            restart;
    logic            line_end;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/utf8_text_to_key_slots_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text to key slot unit
// Decodes one line of UTF-8 text and gives every codepoint a key slot.
// ----------------------------------------------------------------------------
// Usage: text bytes enter on the input channel, one beat per byte, with
// last_byte_i set on the final byte of a line. Each byte that completes a
// character, and each byte at which an error is found, yields one result
// beat on the output channel; lead and inner continuation bytes yield none.
// A result with a nonzero status always ends the line, and the bytes that
// follow it up to the end of the line are swallowed. The consumer must drop
// a whole line whose last result carries an error.
// Throughput is one byte per clock cycle while the input is not stalled: the
// lookup compares the codepoint against every slot cell of the chain in
// parallel, and the update of the table lands in the same cycle. The result
// of an accepted byte is in the output register in the next cycle.
// The input is stalled only while the output register holds a result that
// the receiver is stalling; otherwise a new byte is taken every cycle.
// Reset empties the slot table, clears the character count and any open
// sequence, and drops a pending result. Every line starts with an empty
// table, so slot numbering restarts per line.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_text_to_key_slots_unit_macros.svh"

module utf8_text_to_key_slots_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [utts_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utts_pkg::CP_W-1:0]     code_point_o,
  output logic [utts_pkg::SLOT_W-1:0]   slot_index_o,
  output logic [utts_pkg::KEY_W-1:0]    key_code_o,
  output logic                          new_round_o,
  output logic [1:0]                    status_o,
  output logic                          end_of_line_o
);
  import utts_pkg::*;

  logic                in_acc;
  dec_evt_t            evt;
  cell_cmd_t           cmd;
  logic [KEY_SLOTS-1:0] cell_used;
  logic [KEY_SLOTS-1:0] cell_hit;
  logic [KEY_SLOTS-1:0] cell_front;
  logic                any_hit;
  logic                table_full;
  logic [SLOT_W-1:0]   slot_sel;
  logic [KEY_W-1:0]    key_sel;
  logic                res_go;

  logic                out_valid_q;
  logic [CP_W-1:0]     code_point_q;
  logic [SLOT_W-1:0]   slot_index_q;
  logic [KEY_W-1:0]    key_code_q;
  logic                new_round_q;
  status_e             status_q;
  logic                end_of_line_q;

  // The output register frees up in the same cycle as its beat is taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  utts_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .evt_o       (evt)
  );

  // A miss takes the next free cell; a miss on a full table restarts the round.
  assign any_hit    = |cell_hit;
  assign table_full = cell_used[KEY_SLOTS-1];

  always_comb begin
    cmd          = '0;
    cmd.cp       = evt.cp;
    cmd.alloc    = evt.chr && !any_hit && !table_full;
    cmd.restart  = evt.chr && !any_hit && table_full;
    cmd.line_end = in_acc && last_byte_i;
  end

  // Cells form a chain: each cell's in-use flag tells its neighbour whether
  // it has become the first free slot.
  for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      utts_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .prev_used_i (1'b1),
        .is_first_i  (1'b1),
        .used_o      (cell_used[k]),
        .hit_o       (cell_hit[k]),
        .frontier_o  (cell_front[k])
      );
    end else begin : g_body
      utts_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .prev_used_i (cell_used[k-1]),
        .is_first_i  (1'b0),
        .used_o      (cell_used[k]),
        .hit_o       (cell_hit[k]),
        .frontier_o  (cell_front[k])
      );
    end
  end

  // At most one cell is selected, so the slot number and key code can be
  // gathered with a plain OR over the cells.
  always_comb begin
    slot_sel = '0;
    key_sel  = '0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (cell_hit[k] || (cmd.alloc && cell_front[k])) begin
        slot_sel = slot_sel | SLOT_W'(k);
        key_sel  = key_sel | KEY_CODES[k];
      end
    end
    if (cmd.restart) begin
      slot_sel = '0;
      key_sel  = KEY_CODES[0];
    end
  end

  assign res_go = evt.chr || evt.err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_go) begin
      code_point_q  <= evt.chr ? evt.cp : '0;
      slot_index_q  <= evt.chr ? slot_sel : '0;
      key_code_q    <= evt.chr ? key_sel : '0;
      new_round_q   <= cmd.restart;
      status_q      <= evt.status;
      end_of_line_q <= evt.eol;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = code_point_q;
  assign slot_index_o  = slot_index_q;
  assign key_code_o    = key_code_q;
  assign new_round_o   = new_round_q;
  assign status_o      = status_q;
  assign end_of_line_o = end_of_line_q;

  // Stored codepoints are distinct, so a lookup never hits twice.
  `UTTS_ASSERT_SAME(a_single_hit, 1'b1, $onehot0(cell_hit))
  // Occupied cells always form an unbroken run from slot zero.
  `UTTS_ASSERT_SAME(a_used_run, 1'b1, ((cell_used >> 1) & ~cell_used) == '0)
  // An error result always closes the line.
  `UTTS_ASSERT_SAME(a_err_eol, out_valid_o && status_o != ST_OK, end_of_line_o)
  // The last byte of a line leaves the table empty.
  `UTTS_ASSERT_NEXT(a_line_clear, in_acc && last_byte_i, cell_used == '0)

endmodule

`default_nettype wire

// ===== design/utts_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 key slot unit: byte decoder
// Assembles UTF-8 sequences, checks printability and counts characters.
// ----------------------------------------------------------------------------
`default_nettype none

module utts_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [utts_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic                          last_byte_i,
  output utts_pkg::dec_evt_t            evt_o
);
  import utts_pkg::*;

  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3F;
  localparam logic [CP_W-1:0]   CP_SPACE   = 21'h00020;
  localparam logic [CP_W-1:0]   CP_DEL     = 21'h0007F;
  localparam logic [CP_W-1:0]   CP_MAX     = 21'h10FFFF;
  localparam logic [CNT_W-1:0]  CHAR_LIMIT = CNT_W'(MAX_CHARS);

  logic [CP_W-1:0]  partial_q, partial_d;
  logic [1:0]       left_q, left_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             failed_q, failed_d;
  logic [CP_W-1:0]  pv_next;

  assign pv_next = {partial_q[CP_W-7:0], text_byte_i[5:0] & CONT_DATA[5:0]};

  always_comb begin
    logic            char_go;
    logic [CP_W-1:0] char_cp;
    logic            err_go;
    status_e         err_code;

    char_go   = 1'b0;
    char_cp   = '0;
    err_go    = 1'b0;
    err_code  = ST_BAD;
    evt_o     = '0;
    evt_o.status = ST_OK;
    evt_o.eol = last_byte_i;
    partial_d = partial_q;
    left_d    = left_q;
    count_d   = count_q;
    failed_d  = failed_q;

    if (accept_i && !failed_q) begin
      if (left_q == 2'd0) begin
        priority if (count_q >= CHAR_LIMIT) begin
          err_go   = 1'b1;
          err_code = ST_LIMIT;
        end else if (!text_byte_i[7]) begin
          char_go = 1'b1;
          char_cp = CP_W'(text_byte_i);
        end else if ((text_byte_i & LEAD2_MASK) == LEAD2_PAT) begin
          partial_d = CP_W'(text_byte_i & LEAD2_DATA);
          left_d    = 2'd1;
          err_go    = last_byte_i;
        end else if ((text_byte_i & LEAD3_MASK) == LEAD3_PAT) begin
          partial_d = CP_W'(text_byte_i & LEAD3_DATA);
          left_d    = 2'd2;
          err_go    = last_byte_i;
        end else if ((text_byte_i & LEAD4_MASK) == LEAD4_PAT) begin
          partial_d = CP_W'(text_byte_i & LEAD4_DATA);
          left_d    = 2'd3;
          err_go    = last_byte_i;
        end else begin
          err_go = 1'b1;
        end
      end else begin
        if ((text_byte_i & CONT_MASK) != CONT_PAT) begin
          err_go = 1'b1;
        end else begin
          partial_d = pv_next;
          left_d    = left_q - 2'd1;
          if (left_q == 2'd1) begin
            partial_d = '0;
            char_go   = 1'b1;
            char_cp   = pv_next;
          end else begin
            err_go = last_byte_i;
          end
        end
      end

      if (char_go) begin
        if (char_cp < CP_SPACE || char_cp == CP_DEL || char_cp > CP_MAX) begin
          err_go = 1'b1;
        end else begin
          evt_o.chr = 1'b1;
          evt_o.cp  = char_cp;
          count_d   = count_q + CNT_W'(1);
        end
      end

      if (err_go) begin
        evt_o.err    = 1'b1;
        evt_o.status = err_code;
        evt_o.eol    = 1'b1;
        failed_d     = 1'b1;
        left_d       = 2'd0;
        partial_d    = '0;
      end
    end

    // The final byte of a line always returns the line state to reset.
    if (accept_i && last_byte_i) begin
      partial_d = '0;
      left_d    = 2'd0;
      count_d   = '0;
      failed_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      left_q    <= 2'd0;
      count_q   <= '0;
      failed_q  <= 1'b0;
    end else begin
      partial_q <= partial_d;
      left_q    <= left_d;
      count_q   <= count_d;
      failed_q  <= failed_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/utts_cell.sv =====
// ----------------------------------------------------------------------------
// UTF-8 key slot unit: slot cell
// Holds one table entry; its in-use flag fills from the neighbouring cell.
// ----------------------------------------------------------------------------
`default_nettype none

module utts_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utts_pkg::cell_cmd_t cmd_i,
  input  logic                prev_used_i,
  input  logic                is_first_i,
  output logic                used_o,
  output logic                hit_o,
  output logic                frontier_o
);
  import utts_pkg::*;

  logic            used_q, used_d;
  logic [CP_W-1:0] entry_q;
  logic            write_en;

  assign used_o     = used_q;
  assign hit_o      = used_q && (entry_q == cmd_i.cp);
  // This cell is the next free slot when its neighbour is taken and it is not.
  assign frontier_o = prev_used_i && !used_q;
  assign write_en   = (cmd_i.alloc && frontier_o) || (cmd_i.restart && is_first_i);

  always_comb begin
    used_d = used_q;
    priority if (cmd_i.line_end) begin
      used_d = 1'b0;
    end else if (cmd_i.restart) begin
      used_d = is_first_i;
    end else if (write_en) begin
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      entry_q <= cmd_i.cp;
    end
  end

endmodule

`default_nettype wire
